### hw/rtl/broadcast_index_generator_core_macros.svh
// Assertion macros shared by the broadcast index generator RTL.
`ifndef BROADCAST_INDEX_GENERATOR_CORE_MACROS_SVH
`define BROADCAST_INDEX_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication check under the active-low reset.
`define BIC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle implication check failed.");

// Next-cycle implication check under the active-low reset.
`define BIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle implication check failed.");

`endif

### hw/rtl/bic_pkg.sv
// Shared types and constants of the broadcast index generator.
package bic_pkg;

    localparam int IDX_W = 32;
    localparam int DIM_W = 16;

    typedef enum logic [2:0]
    {
        REG_AXIS_COUNT    = 3'd0,
        REG_OUT_DIMS      = 3'd1,
        REG_FIRST_DIMS    = 3'd2,
        REG_SECOND_DIMS   = 3'd3,
        REG_ELEMENT_COUNT = 3'd4
    } bic_reg_t;

    typedef struct packed
    {
        logic [DIM_W-1:0] od;
        logic [DIM_W-1:0] fd;
        logic [DIM_W-1:0] sd;
    } bic_dims_t;

endpackage

### hw/rtl/broadcast_index_generator_core.sv
// Each index passes the entry register, then every axis slice in turn, then the output register.
// Throughput: one item per cycle while the output is not stalled; each axis slice is a bit-per-stage divider pipeline.
// The whole pipeline advances when the output register is empty or its item is taken.
// Reset is asynchronous and active low; it clears all valid bits and loads register defaults.
// Stride registers settle after a shape write, each built from the registered dimensions of the previous position.
module broadcast_index_generator_core #(
    parameter int MAX_AXES   = 4,
    parameter int INDEX_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] out_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] first_index, [63:32] second_index
    output logic [0:0]  m_tuser,   // [0] out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import bic_pkg::*;
    `include "broadcast_index_generator_core_macros.svh"

    logic [2:0]        axis_count_reg;
    logic [63:0]       out_dims_reg;
    logic [63:0]       first_dims_reg;
    logic [63:0]       second_dims_reg;
    logic [IDX_W-1:0]  element_count_reg;

    logic [2:0]        axes;
    logic              en;

    bic_dims_t             dims_eff_reg [MAX_AXES];
    logic [INDEX_BITS-1:0] fstride_reg  [MAX_AXES];
    logic [INDEX_BITS-1:0] sstride_reg  [MAX_AXES];

    logic              v0_reg;
    logic              oor0_reg;
    logic [IDX_W-1:0]  idx0_reg;

    logic                  ax_v    [MAX_AXES];
    logic                  ax_oor  [MAX_AXES];
    logic [IDX_W-1:0]      ax_rest [MAX_AXES];
    logic [INDEX_BITS-1:0] ax_facc [MAX_AXES];
    logic [INDEX_BITS-1:0] ax_sacc [MAX_AXES];

    logic [INDEX_BITS+IDX_W-1:0] f_ext;
    logic [INDEX_BITS+IDX_W-1:0] s_ext;

    logic              m_tvalid_reg;
    logic              m_oor_reg;
    logic [IDX_W-1:0]  m_first_reg;
    logic [IDX_W-1:0]  m_second_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg    <= 3'd1;
            out_dims_reg      <= 64'h0001_0001_0001_0001;
            first_dims_reg    <= 64'h0001_0001_0001_0001;
            second_dims_reg   <= 64'h0001_0001_0001_0001;
            element_count_reg <= 32'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[5:3])
                REG_AXIS_COUNT:    axis_count_reg    <= pwdata[2:0];
                REG_OUT_DIMS:      out_dims_reg      <= pwdata;
                REG_FIRST_DIMS:    first_dims_reg    <= pwdata;
                REG_SECOND_DIMS:   second_dims_reg   <= pwdata;
                REG_ELEMENT_COUNT: element_count_reg <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_AXIS_COUNT:    prdata = {61'd0, axis_count_reg};
            REG_OUT_DIMS:      prdata = out_dims_reg;
            REG_FIRST_DIMS:    prdata = first_dims_reg;
            REG_SECOND_DIMS:   prdata = second_dims_reg;
            REG_ELEMENT_COUNT: prdata = {32'd0, element_count_reg};
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        if (axis_count_reg == 3'd0)
            axes = 3'd1;
        else if (axis_count_reg > 3'(MAX_AXES))
            axes = 3'(MAX_AXES);
        else
            axes = axis_count_reg;
    end

    // Pipeline position j works on axis axes-1-j, innermost first; unused positions see ones.
    for (genvar j = 0; j < MAX_AXES; j++)
    begin : g_pos
        logic [2:0]       n;
        logic             used;
        logic [DIM_W-1:0] od_raw;
        logic [DIM_W-1:0] fd_raw;
        logic [DIM_W-1:0] sd_raw;
        bic_dims_t        eff;

        assign n      = axes - 3'(j) - 3'd1;
        assign used   = 3'(j) < axes;
        assign od_raw = out_dims_reg[{n[1:0], 4'b0000} +: DIM_W];
        assign fd_raw = first_dims_reg[{n[1:0], 4'b0000} +: DIM_W];
        assign sd_raw = second_dims_reg[{n[1:0], 4'b0000} +: DIM_W];

        always_comb
        begin
            eff.od = (!used || od_raw == '0) ? DIM_W'(1) : od_raw;
            eff.fd = (!used || fd_raw == '0) ? DIM_W'(1) : fd_raw;
            eff.sd = (!used || sd_raw == '0) ? DIM_W'(1) : sd_raw;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dims_eff_reg[j] <= '{od: DIM_W'(1), fd: DIM_W'(1), sd: DIM_W'(1)};
            else
                dims_eff_reg[j] <= eff;
        end

        if (j == 0)
        begin : g_unit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    fstride_reg[j] <= INDEX_BITS'(1);
                    sstride_reg[j] <= INDEX_BITS'(1);
                end
                else
                begin
                    fstride_reg[j] <= INDEX_BITS'(1);
                    sstride_reg[j] <= INDEX_BITS'(1);
                end
            end
        end
        else
        begin : g_chain
            logic [DIM_W+INDEX_BITS-1:0] fp;
            logic [DIM_W+INDEX_BITS-1:0] sp;

            assign fp = fstride_reg[j-1] * dims_eff_reg[j-1].fd;
            assign sp = sstride_reg[j-1] * dims_eff_reg[j-1].sd;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    fstride_reg[j] <= INDEX_BITS'(1);
                    sstride_reg[j] <= INDEX_BITS'(1);
                end
                else
                begin
                    fstride_reg[j] <= fp[INDEX_BITS-1:0];
                    sstride_reg[j] <= sp[INDEX_BITS-1:0];
                end
            end
        end
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx0_reg <= s_tdata;
            oor0_reg <= s_tdata >= element_count_reg;
        end
    end

    for (genvar j = 0; j < MAX_AXES; j++)
    begin : g_ax
        logic                  v_in;
        logic                  oor_in;
        logic [IDX_W-1:0]      rest_in;
        logic [INDEX_BITS-1:0] facc_in;
        logic [INDEX_BITS-1:0] sacc_in;

        if (j == 0)
        begin : g_first
            assign v_in    = v0_reg;
            assign oor_in  = oor0_reg;
            assign rest_in = idx0_reg;
            assign facc_in = '0;
            assign sacc_in = '0;
        end
        else
        begin : g_next
            assign v_in    = ax_v[j-1];
            assign oor_in  = ax_oor[j-1];
            assign rest_in = ax_rest[j-1];
            assign facc_in = ax_facc[j-1];
            assign sacc_in = ax_sacc[j-1];
        end

        bic_axis #(
            .INDEX_BITS (INDEX_BITS)
        ) u_axis (
            .clk            (clk),
            .rst_n          (rst_n),
            .en             (en),
            .dims           (dims_eff_reg[j]),
            .first_stride   (fstride_reg[j]),
            .second_stride  (sstride_reg[j]),
            .in_valid       (v_in),
            .in_oor         (oor_in),
            .in_rest        (rest_in),
            .in_first_acc   (facc_in),
            .in_second_acc  (sacc_in),
            .out_valid      (ax_v[j]),
            .out_oor        (ax_oor[j]),
            .out_rest       (ax_rest[j]),
            .out_first_acc  (ax_facc[j]),
            .out_second_acc (ax_sacc[j])
        );
    end

    assign f_ext = {{IDX_W{1'b0}}, ax_facc[MAX_AXES-1]};
    assign s_ext = {{IDX_W{1'b0}}, ax_sacc[MAX_AXES-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= ax_v[MAX_AXES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_oor_reg    <= ax_oor[MAX_AXES-1];
            m_first_reg  <= ax_oor[MAX_AXES-1] ? '0 : f_ext[IDX_W-1:0];
            m_second_reg <= ax_oor[MAX_AXES-1] ? '0 : s_ext[IDX_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_second_reg, m_first_reg};
    assign m_tuser  = m_oor_reg;

    `BIC_ASSERT_IMPLY(a_oor_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata == 64'd0)
    `BIC_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)
    `BIC_ASSERT_NEXT(a_entry_flag, clk, rst_n, s_tvalid && s_tready, v0_reg && (oor0_reg == ($past(s_tdata) >= $past(element_count_reg))))

endmodule

### hw/rtl/bic_axis.sv
// Pipelined per-axis slice: coordinate split, operand wrap and stride weighting.
module bic_axis #(
    parameter int INDEX_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  bic_pkg::bic_dims_t         dims,
    input  logic [INDEX_BITS-1:0]      first_stride,
    input  logic [INDEX_BITS-1:0]      second_stride,
    input  logic                       in_valid,
    input  logic                       in_oor,
    input  logic [bic_pkg::IDX_W-1:0]  in_rest,
    input  logic [INDEX_BITS-1:0]      in_first_acc,
    input  logic [INDEX_BITS-1:0]      in_second_acc,
    output logic                       out_valid,
    output logic                       out_oor,
    output logic [bic_pkg::IDX_W-1:0]  out_rest,
    output logic [INDEX_BITS-1:0]      out_first_acc,
    output logic [INDEX_BITS-1:0]      out_second_acc
);
    import bic_pkg::*;

    typedef struct packed
    {
        logic                  oor;
        logic [IDX_W-1:0]      rest;
        logic [INDEX_BITS-1:0] facc;
        logic [INDEX_BITS-1:0] sacc;
    } carry_t;

    logic                  a_v_reg [IDX_W];
    carry_t                a_c_reg [IDX_W];
    logic [DIM_W-1:0]      a_r_reg [IDX_W];
    logic [IDX_W-1:0]      a_w_reg [IDX_W];

    logic                  b_v_reg  [DIM_W];
    carry_t                b_c_reg  [DIM_W];
    logic [DIM_W-1:0]      b_fr_reg [DIM_W];
    logic [DIM_W-1:0]      b_fw_reg [DIM_W];
    logic [DIM_W-1:0]      b_sr_reg [DIM_W];
    logic [DIM_W-1:0]      b_sw_reg [DIM_W];

    logic                  c_v_reg;
    carry_t                c_c_reg;
    logic [INDEX_BITS-1:0] c_pf_reg;
    logic [INDEX_BITS-1:0] c_ps_reg;

    logic                  d_v_reg;
    carry_t                d_c_reg;

    carry_t                b_start;
    logic [DIM_W+INDEX_BITS-1:0] prod_f;
    logic [DIM_W+INDEX_BITS-1:0] prod_s;

    // The output coordinate is the remainder of the running index by the output dimension.
    for (genvar i = 0; i < IDX_W; i++)
    begin : g_a
        logic             v_in;
        carry_t           c_in;
        logic [DIM_W-1:0] r_in;
        logic [IDX_W-1:0] w_in;
        logic [DIM_W:0]   t;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign v_in = in_valid;
            assign c_in = {in_oor, in_rest, in_first_acc, in_second_acc};
            assign r_in = '0;
            assign w_in = in_rest;
        end
        else
        begin : g_next
            assign v_in = a_v_reg[i-1];
            assign c_in = a_c_reg[i-1];
            assign r_in = a_r_reg[i-1];
            assign w_in = a_w_reg[i-1];
        end

        assign t  = {r_in, w_in[IDX_W-1]};
        assign ge = t >= {1'b0, dims.od};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                a_v_reg[i] <= 1'b0;
            else if (en)
                a_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_c_reg[i] <= c_in;
                a_r_reg[i] <= ge ? DIM_W'(t - {1'b0, dims.od}) : t[DIM_W-1:0];
                a_w_reg[i] <= {w_in[IDX_W-2:0], ge};
            end
        end
    end

    always_comb
    begin
        b_start      = a_c_reg[IDX_W-1];
        b_start.rest = a_w_reg[IDX_W-1];
    end

    // The coordinate wraps onto each operand dimension.
    for (genvar i = 0; i < DIM_W; i++)
    begin : g_b
        logic             v_in;
        carry_t           c_in;
        logic [DIM_W-1:0] fr_in;
        logic [DIM_W-1:0] fw_in;
        logic [DIM_W-1:0] sr_in;
        logic [DIM_W-1:0] sw_in;
        logic [DIM_W:0]   tf;
        logic [DIM_W:0]   ts;
        logic             gef;
        logic             ges;

        if (i == 0)
        begin : g_first
            assign v_in  = a_v_reg[IDX_W-1];
            assign c_in  = b_start;
            assign fr_in = '0;
            assign fw_in = a_r_reg[IDX_W-1];
            assign sr_in = '0;
            assign sw_in = a_r_reg[IDX_W-1];
        end
        else
        begin : g_next
            assign v_in  = b_v_reg[i-1];
            assign c_in  = b_c_reg[i-1];
            assign fr_in = b_fr_reg[i-1];
            assign fw_in = b_fw_reg[i-1];
            assign sr_in = b_sr_reg[i-1];
            assign sw_in = b_sw_reg[i-1];
        end

        assign tf  = {fr_in, fw_in[DIM_W-1]};
        assign ts  = {sr_in, sw_in[DIM_W-1]};
        assign gef = tf >= {1'b0, dims.fd};
        assign ges = ts >= {1'b0, dims.sd};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                b_v_reg[i] <= 1'b0;
            else if (en)
                b_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                b_c_reg[i]  <= c_in;
                b_fr_reg[i] <= gef ? DIM_W'(tf - {1'b0, dims.fd}) : tf[DIM_W-1:0];
                b_fw_reg[i] <= {fw_in[DIM_W-2:0], gef};
                b_sr_reg[i] <= ges ? DIM_W'(ts - {1'b0, dims.sd}) : ts[DIM_W-1:0];
                b_sw_reg[i] <= {sw_in[DIM_W-2:0], ges};
            end
        end
    end

    assign prod_f = b_fr_reg[DIM_W-1] * first_stride;
    assign prod_s = b_sr_reg[DIM_W-1] * second_stride;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg <= b_v_reg[DIM_W-1];
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_c_reg      <= b_c_reg[DIM_W-1];
            c_pf_reg     <= prod_f[INDEX_BITS-1:0];
            c_ps_reg     <= prod_s[INDEX_BITS-1:0];
            d_c_reg.oor  <= c_c_reg.oor;
            d_c_reg.rest <= c_c_reg.rest;
            d_c_reg.facc <= c_c_reg.facc + c_pf_reg;
            d_c_reg.sacc <= c_c_reg.sacc + c_ps_reg;
        end
    end

    assign out_valid      = d_v_reg;
    assign out_oor        = d_c_reg.oor;
    assign out_rest       = d_c_reg.rest;
    assign out_first_acc  = d_c_reg.facc;
    assign out_second_acc = d_c_reg.sacc;

endmodule

### verif/tb_broadcast_index_generator_core.sv
// Self-checking testbench for the broadcast index generator core.
`timescale 1ns / 1ps

import bic_pkg::*;

typedef struct
{
    logic [31:0] first_index;
    logic [31:0] second_index;
    logic        out_of_range;
} bic_index_pair_t;

class index_scoreboard;
    logic [2:0]      axis_count;
    logic [63:0]     out_dims;
    logic [63:0]     first_dims;
    logic [63:0]     second_dims;
    logic [31:0]     element_count;
    bic_index_pair_t expected_pairs[$];
    int              mismatches;

    function new();
        axis_count    = 3'd1;
        out_dims      = 64'h0001_0001_0001_0001;
        first_dims    = 64'h0001_0001_0001_0001;
        second_dims   = 64'h0001_0001_0001_0001;
        element_count = 32'd1;
        mismatches    = 0;
    endfunction

    function void set_reg(bic_reg_t r, logic [63:0] v);
        case (r)
            REG_AXIS_COUNT:    axis_count = v[2:0];
            REG_OUT_DIMS:      out_dims = v;
            REG_FIRST_DIMS:    first_dims = v;
            REG_SECOND_DIMS:   second_dims = v;
            REG_ELEMENT_COUNT: element_count = v[31:0];
            default:           ;
        endcase
    endfunction

    function longint unsigned dim_at(logic [63:0] packed_dims, int axis);
        longint unsigned d;
        d = packed_dims[axis*DIM_W +: DIM_W];
        return (d == 0) ? 1 : d;
    endfunction

    function void note_input(logic [31:0] out_index);
        bic_index_pair_t p;
        int axes;
        longint unsigned rest, od, fd, sd, coord, f_stride, s_stride, f_acc, s_acc;
        axes = (axis_count == 0) ? 1 : ((axis_count > 4) ? 4 : axis_count);
        p.first_index = '0;
        p.second_index = '0;
        p.out_of_range = 1'b1;
        if (out_index < element_count)
        begin
            rest = out_index;
            f_stride = 1;
            s_stride = 1;
            f_acc = 0;
            s_acc = 0;
            for (int n = axes - 1; n >= 0; n--)
            begin
                od = dim_at(out_dims, n);
                fd = dim_at(first_dims, n);
                sd = dim_at(second_dims, n);
                coord = rest % od;
                rest = rest / od;
                f_acc += (coord % fd) * f_stride;
                s_acc += (coord % sd) * s_stride;
                f_stride *= fd;
                s_stride *= sd;
            end
            p.first_index = f_acc[31:0];
            p.second_index = s_acc[31:0];
            p.out_of_range = 1'b0;
        end
        expected_pairs.push_back(p);
    endfunction

    function void check_result(logic [63:0] tdata, logic tuser);
        bic_index_pair_t p;
        if (expected_pairs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: data %h flag %b", tdata, tuser);
            return;
        end
        p = expected_pairs.pop_front();
        if (tdata[31:0] !== p.first_index || tdata[63:32] !== p.second_index
            || tuser !== p.out_of_range)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h %h %b, got %h %h %b",
                         p.first_index, p.second_index, p.out_of_range,
                         tdata[31:0], tdata[63:32], tuser);
        end
    endfunction
endclass

module tb_broadcast_index_generator_core;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] out_index
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] first_index, [63:32] second_index
    logic [0:0]  m_tuser;   // [0] out_of_range
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    index_scoreboard pairs_sb;
    int          ready_mode;
    logic        hold_req;
    logic        hold_seen;
    int          hold_left;
    int          cycle_count;

    broadcast_index_generator_core i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pairs_sb.check_result(m_tdata, m_tuser[0]);
    end

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                default: m_tready <= (cycle_count % 11) < 6;
            endcase
        end
    end

    task automatic write_reg(bic_reg_t r, logic [63:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(r) << 3;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pairs_sb.set_reg(r, v);
    endtask

    task automatic set_shape(logic [2:0] axes, logic [63:0] od, logic [63:0] fd,
                             logic [63:0] sd, logic [31:0] count);
        write_reg(REG_AXIS_COUNT, {61'd0, axes});
        write_reg(REG_OUT_DIMS, od);
        write_reg(REG_FIRST_DIMS, fd);
        write_reg(REG_SECOND_DIMS, sd);
        write_reg(REG_ELEMENT_COUNT, {32'd0, count});
        repeat (8) @(posedge clk);
    endtask

    task automatic send_index(logic [31:0] v);
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do
            @(posedge clk);
        while (!s_tready);
        pairs_sb.note_input(v);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pairs_sb.expected_pairs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 16'($urandom_range(1, 6));
        else if (r < 7)
            return 16'd1;
        else if (r < 8)
            return 16'd0;
        return 16'($urandom);
    endfunction

    task automatic random_phase(int items, bit long_hold);
        logic [63:0] od, fd, sd;
        logic [31:0] count;
        logic [31:0] v;
        longint unsigned prod;
        int sent;
        int burst;
        od = '0;
        fd = '0;
        sd = '0;
        prod = 1;
        for (int n = 0; n < 4; n++)
        begin
            od[n*16 +: 16] = pick_dim();
            case ($urandom_range(0, 2))
                0: fd[n*16 +: 16] = od[n*16 +: 16];
                1: fd[n*16 +: 16] = 16'd1;
                default: fd[n*16 +: 16] = pick_dim();
            endcase
            case ($urandom_range(0, 2))
                0: sd[n*16 +: 16] = od[n*16 +: 16];
                1: sd[n*16 +: 16] = 16'd1;
                default: sd[n*16 +: 16] = pick_dim();
            endcase
            prod *= (od[n*16 +: 16] == 0) ? 1 : od[n*16 +: 16];
        end
        count = ($urandom_range(0, 3) == 0) ? $urandom : prod[31:0];
        set_shape(3'($urandom), od, fd, sd, count);
        ready_mode = $urandom_range(0, 2);
        sent = 0;
        while (sent < items)
        begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && sent < items; b++)
            begin
                if (long_hold && sent == 20)
                    hold_req = ~hold_req;
                if (count != 0 && $urandom_range(0, 3) != 0)
                    v = $urandom_range(0, count - 1);
                else
                    v = $urandom;
                send_index(v);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 15));
        end
        drain_results();
    endtask

    initial
    begin
        pairs_sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ready_mode = 0;
        hold_req = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        m_tready = 1'b0;
        cycle_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        send_index(32'd0);
        send_index(32'd1);
        send_index(32'hFFFF_FFFF);
        drain_results();

        set_shape(3'd4, 64'h0002_0003_0004_0005, 64'h0001_0003_0001_0005,
                  64'h0002_0001_0004_0001, 32'd120);
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'd59);
        send_index(32'd119);
        send_index(32'd120);
        send_index(32'hFFFF_FFFF);
        drain_results();

        // Zero dimensions and an axis count of zero.
        set_shape(3'd0, 64'h0000_0000_0000_0007, 64'h0000_0000_0000_0003,
                  64'h0000_0000_0000_0000, 32'd100);
        send_index(32'd6);
        send_index(32'd50);
        drain_results();

        // Axis count above the maximum and full-size dimensions.
        set_shape(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_0001_FFFF_0001,
                  64'h0001_FFFF_0001_FFFF, 32'hFFFF_FFFF);
        send_index(32'hFFFF_FFFE);
        send_index(32'h8000_0000);
        send_index(32'h1234_5678);
        drain_results();

        // Nothing is in range with a zero element count.
        set_shape(3'd2, 64'h0000_0000_0004_0004, 64'h0000_0000_0004_0001,
                  64'h0000_0000_0001_0004, 32'd0);
        send_index(32'd0);
        send_index(32'd3);
        drain_results();

        // Small tiled operand dimensions.
        set_shape(3'd3, 64'h0000_0006_0004_0009, 64'h0000_0003_0002_0003,
                  64'h0000_0002_0004_0001, 32'd216);
        send_index(32'd215);
        send_index(32'd100);
        drain_results();

        random_phase(150, 1'b1);
        for (int p = 0; p < 8; p++)
            random_phase(155, 1'b0);

        drain_results();
        repeat (210) @(posedge clk);
        if (pairs_sb.mismatches == 0 && pairs_sb.expected_pairs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### broadcast_index_generator_core.f
+incdir+hw/rtl
hw/rtl/bic_pkg.sv
hw/rtl/bic_axis.sv
hw/rtl/broadcast_index_generator_core.sv
verif/tb_broadcast_index_generator_core.sv
